/* rtl/ptsb_pkg.sv */
`default_nettype none
package ptsb_pkg;

  // Number of timer slots in the bank (1 to 64).
  localparam int SlotCount = 16;
  localparam int SlotIdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  // Width used to compare a requested slot number with a cell's own number.
  localparam int IdxCmpW   = (SlotIdxW > 4) ? SlotIdxW : 4;

  localparam int PeriodW   = 32;
  localparam int MaskW     = 16;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               tick;
    logic               add;
    logic [PeriodW-1:0] period;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* rtl/periodic_timer_slot_bank_core.sv */
`default_nettype none
// The result word is registered and appears in the cycle after the command word is taken,
// with out_valid high for exactly that cycle.
// Throughput: one command word per cycle; busy stays low, and the search for
// the lowest free slot ripples combinationally through the chain of slot cells.
// Reset (synchronous, active low) marks every slot free and clears the tick count.
module periodic_timer_slot_bank_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic [ptsb_pkg::PeriodW-1:0]      in_period,
  input  logic [3:0]                        in_slot_index,
  output logic                              out_valid,
  output logic [ptsb_pkg::MaskW-1:0]        out_fired_mask,
  output logic [3:0]                        out_added_slot,
  output logic                              out_table_full,
  output logic [ptsb_pkg::PeriodW-1:0]      out_tick_count
);
  import ptsb_pkg::*;

  // Every command completes in the cycle it is taken, so the bank never
  // refuses a word.
  assign busy = 1'b0;

  logic                 accept;
  logic                 is_tick, is_add, is_remove;
  cell_cmd_t            cmd;
  logic [SlotCount:0]   claim;
  logic [SlotCount-1:0] fired;
  logic [SlotCount-1:0] took;
  logic [SlotCount-1:0] remove_hit;

  logic                 out_valid_r;
  logic [MaskW-1:0]     fired_mask_r, fired_mask_nxt;
  logic [3:0]           added_slot_r, added_slot_nxt;
  logic                 table_full_r, table_full_nxt;
  logic [PeriodW-1:0]   tick_total_r, tick_total_nxt;

  assign accept    = start & ~busy;
  assign is_tick   = accept & (in_kind == KIND_TICK);
  assign is_add    = accept & (in_kind == KIND_ADD);
  assign is_remove = accept & (in_kind == KIND_REMOVE);

  assign cmd.tick   = is_tick;
  assign cmd.add    = is_add;
  assign cmd.period = in_period;

  // The claim token enters at slot 0; whichever free cell sees it first
  // takes the add and passes the token on as already used.
  assign claim[0] = 1'b0;

  for (genvar g = 0; g < SlotCount; g++) begin : g_cell
    // A slot number that is not below the bank size matches no cell and is
    // therefore ignored.
    assign remove_hit[g] = is_remove &
                           (IdxCmpW'(in_slot_index) == IdxCmpW'(g));

    ptsb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .remove_hit (remove_hit[g]),
      .claim_in   (claim[g]),
      .claim_out  (claim[g+1]),
      .fired      (fired[g]),
      .took       (took[g])
    );
  end

  // Only the first sixteen slots are reported in the fired mask.
  for (genvar b = 0; b < MaskW; b++) begin : g_mask
    if (b < SlotCount) begin : g_used
      assign fired_mask_nxt[b] = fired[b];
    end else begin : g_spare
      assign fired_mask_nxt[b] = 1'b0;
    end
  end

  // At most one cell takes an add, so an OR of the taken slot numbers gives
  // the slot that was used; the result holds its low four bits.
  always_comb begin
    added_slot_nxt = '0;
    for (int i = 0; i < SlotCount; i++) begin
      if (took[i]) begin
        added_slot_nxt = added_slot_nxt | 4'(i);
      end
    end
  end

  // The add falls off the end of the chain when every slot is busy.
  assign table_full_nxt = is_add & ~claim[SlotCount];
  assign tick_total_nxt = is_tick ? tick_total_r + PeriodW'(1) : tick_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      tick_total_r <= '0;
    end else begin
      out_valid_r  <= accept;
      tick_total_r <= tick_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fired_mask_r <= fired_mask_nxt;
    added_slot_r <= added_slot_nxt;
    table_full_r <= table_full_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired_mask = fired_mask_r;
  assign out_added_slot = added_slot_r;
  assign out_table_full = table_full_r;
  assign out_tick_count = tick_total_r;

endmodule
`default_nettype wire

/* rtl/ptsb_cell.sv */
`default_nettype none
module ptsb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ptsb_pkg::cell_cmd_t cmd,
  input  logic                remove_hit,
  input  logic                claim_in,
  output logic                claim_out,
  output logic                fired,
  output logic                took
);
  import ptsb_pkg::*;

  logic               active_r, active_nxt;
  logic [PeriodW-1:0] reload_r, reload_nxt;
  logic [PeriodW-1:0] current_r, current_nxt;
  logic [PeriodW-1:0] dec;

  // An earlier free cell, or this one, absorbs an add.
  assign claim_out = claim_in | ~active_r;
  assign took      = cmd.add & ~active_r & ~claim_in;
  assign dec       = current_r - PeriodW'(1);

  always_comb begin
    active_nxt  = active_r;
    reload_nxt  = reload_r;
    current_nxt = current_r;
    fired       = 1'b0;
    if (cmd.tick && active_r) begin
      if (dec == '0) begin
        current_nxt = reload_r;
        fired       = 1'b1;
      end else begin
        current_nxt = dec;
      end
    end else if (took) begin
      active_nxt  = 1'b1;
      reload_nxt  = cmd.period;
      current_nxt = cmd.period;
    end else if (remove_hit) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reload_r  <= reload_nxt;
    current_r <= current_nxt;
  end

endmodule
`default_nettype wire

/* rtl/ptsb_checker.sv */
`default_nettype none
module ptsb_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic                         out_valid,
  input  logic [ptsb_pkg::MaskW-1:0]   out_fired_mask,
  input  logic [3:0]                   out_added_slot,
  input  logic                         out_table_full,
  input  logic [ptsb_pkg::PeriodW-1:0] out_tick_count
);
  import ptsb_pkg::*;

  // Exactly one result word follows each accepted command word.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after an accepted word");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted word");

  // Commands other than ticks never report expiries.
  a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind != KIND_TICK) |=> (out_fired_mask == '0))
    else $error("fired mask set by a non-tick word");

  // A dropped add reports no slot.
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_added_slot == '0))
    else $error("slot reported for a dropped add");

  // Back-to-back ticks advance the tick count by one.
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_TICK) ##1 (start && !busy && in_kind == KIND_TICK)
    |=> (out_tick_count == $past(out_tick_count) + PeriodW'(1)))
    else $error("tick count did not advance by one");

endmodule

bind periodic_timer_slot_bank_core ptsb_checker u_ptsb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_fired_mask (out_fired_mask),
  .out_added_slot (out_added_slot),
  .out_table_full (out_table_full),
  .out_tick_count (out_tick_count)
);
`default_nettype wire
